>>> design/btr_pkg.sv
// Package with payload types and protocol constants of the transport reassembler.
`timescale 1ns / 1ps
`default_nettype none
package btr_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  src_addr;
      logic [7:0]  dst_addr;
      logic [3:0]  frame_len;
      logic [63:0] frame_data;
      logic [1:0]  read_slot;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  slot;
      logic [23:0] pgn;
      logic [7:0]  msg_source;
      logic [10:0] msg_len;
      logic [55:0] word_data;
   } rsp_type;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_CTRL = 2'd1;
   localparam logic [1:0] ACT_DATA = 2'd2;
   localparam logic [1:0] ACT_READ = 2'd3;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_OPENED   = 3'd1;
   localparam logic [2:0] ST_STORED   = 3'd2;
   localparam logic [2:0] ST_OUT_SEQ  = 3'd3;
   localparam logic [2:0] ST_COMPLETE = 3'd4;
   localparam logic [2:0] ST_DROPPED  = 3'd5;
   localparam logic [2:0] ST_NO_SLOT  = 3'd6;
   localparam logic [2:0] ST_READ     = 3'd7;

   localparam logic [7:0]  CTRL_BAM   = 8'd32;
   localparam logic [7:0]  BROADCAST  = 8'hFF;
   localparam int          WORD_BYTES = 7;

   localparam logic       REG_TIMEOUT = 1'b0;
   localparam logic       REG_MAX_LEN = 1'b1;
   localparam logic [31:0] TIMEOUT_RESET = 32'd750;
   localparam logic [10:0] MAX_LEN_RESET = 11'd1785;

endpackage
`default_nettype wire

>>> design/btr_payload_ram.sv
// Payload word memory with byte-enable writes and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module btr_payload_ram #(
   parameter int DEPTH  = 1020,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [6:0]        wr_be,
   input  wire logic [55:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [55:0]       rd_data_ff
);

   logic [55:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < 7; b++) begin
            if (wr_be[b]) begin
               mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> design/bam_transport_reassembler.sv
// One item is in work at a time; the slot table is swept one slot per cycle for control
// and data frames.
// A finished result waits in the output register while the next item is accepted.
// Reset clears the session valid bits, tick counter, state and handshakes and loads the
// configuration registers with their reset values; the payload memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bam_transport_reassembler #(
   parameter int SESSION_SLOTS       = 4,
   parameter int PACKETS_PER_MESSAGE = 255
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire btr_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output btr_pkg::rsp_type      rsp_payload,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);

   localparam int DEPTH  = SESSION_SLOTS * PACKETS_PER_MESSAGE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SESSION_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CLR, S_OPEN, S_DROP, S_MATCH, S_PROC, S_READ, S_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   btr_pkg::req_type      item_ff, item_in;
   btr_pkg::rsp_type      res_ff, res_in;
   btr_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           tick_ff, tick_in;
   logic [31:0]           timeout_ff;
   logic [10:0]           maxlen_ff;

   logic [SESSION_SLOTS-1:0] act_ff, act_in;
   logic [7:0]  src_ff [SESSION_SLOTS];
   logic [7:0]  src_in [SESSION_SLOTS];
   logic [23:0] pgn_ff [SESSION_SLOTS];
   logic [23:0] pgn_in [SESSION_SLOTS];
   logic [10:0] tot_ff [SESSION_SLOTS];
   logic [10:0] tot_in [SESSION_SLOTS];
   logic [7:0]  left_ff [SESSION_SLOTS];
   logic [7:0]  left_in [SESSION_SLOTS];
   logic [7:0]  exp_ff [SESSION_SLOTS];
   logic [7:0]  exp_in [SESSION_SLOTS];
   logic [31:0] last_ff [SESSION_SLOTS];
   logic [31:0] last_in [SESSION_SLOTS];

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [6:0]        wr_be;
   logic [55:0]       rd_data;

   logic        rsp_free, last_k, cfg_wr;
   logic [15:0] ctl_total;
   logic [7:0]  pn;
   logic [3:0]  ch0;
   logic [2:0]  ch1, chunk;
   logic [11:0] off, end1, end2;
   logic [31:0] elapsed;

   btr_payload_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_be      (wr_be),
      .wr_data    (item_ff.frame_data[63:8]),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign last_k      = (cnt_ff == LAST_SLOT);
   assign pready      = 1'b1;
   assign cfg_wr      = psel && penable && pwrite;
   assign prdata      = (paddr[2] == btr_pkg::REG_MAX_LEN) ? {21'd0, maxlen_ff} : timeout_ff;

   assign ctl_total = {item_ff.frame_data[23:16], item_ff.frame_data[15:8]};
   assign elapsed   = tick_ff - last_ff[cnt_ff];

   // Chunk length: one byte of the frame is the sequence number, then clip at seven bytes and at the total.
   assign pn   = item_ff.frame_data[7:0];
   assign ch0  = (item_ff.frame_len > 4'd1) ? item_ff.frame_len - 4'd1 : 4'd0;
   assign ch1  = (ch0 > 4'd7) ? 3'd7 : ch0[2:0];
   assign off  = 12'(({4'd0, pn} - 12'd1) * 12'(btr_pkg::WORD_BYTES));
   assign end1 = off + {9'd0, ch1};
   always_comb begin
      if (end1 > {1'b0, tot_ff[slot_ff]}) begin
         chunk = ({1'b0, tot_ff[slot_ff]} > off) ? 3'({1'b0, tot_ff[slot_ff]} - off) : 3'd0;
      end else begin
         chunk = ch1;
      end
   end
   assign end2 = off + {9'd0, chunk};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tick_in      = tick_ff;
      act_in       = act_ff;
      src_in       = src_ff;
      pgn_in       = pgn_ff;
      tot_in       = tot_ff;
      left_in      = left_ff;
      exp_in       = exp_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(32'(slot_ff) * 32'(PACKETS_PER_MESSAGE) + 32'(pn) - 32'd1);
      for (int b = 0; b < 7; b++) begin
         wr_be[b] = (3'(b) < chunk);
      end
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(32'(req_payload.read_slot) * 32'(PACKETS_PER_MESSAGE)
                        + 32'(req_payload.read_index));

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               cnt_in  = '0;
               res_in  = '0;
               unique case (req_payload.action)
                  btr_pkg::ACT_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     state_in = S_RESP;
                  end
                  btr_pkg::ACT_CTRL: state_in = S_CLR;
                  btr_pkg::ACT_DATA: state_in = S_DROP;
                  btr_pkg::ACT_READ: begin
                     res_in.status = btr_pkg::ST_READ;
                     res_in.slot   = req_payload.read_slot;
                     if (32'(req_payload.read_slot) < 32'(SESSION_SLOTS) &&
                         32'(req_payload.read_index) < 32'(PACKETS_PER_MESSAGE)) begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_CLR: begin
            // Reject a malformed announce before any session is touched.
            if (item_ff.frame_data[7:0] != btr_pkg::CTRL_BAM ||
                item_ff.dst_addr != btr_pkg::BROADCAST ||
                ctl_total == 16'd0 || ctl_total > {5'd0, maxlen_ff}) begin
               state_in = S_RESP;
            end else begin
               if (act_ff[cnt_ff] && src_ff[cnt_ff] == item_ff.src_addr) begin
                  act_in[cnt_ff] = 1'b0;
               end
               if (last_k) begin
                  cnt_in   = '0;
                  state_in = S_OPEN;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_OPEN: begin
            if (!act_ff[cnt_ff]) begin
               act_in[cnt_ff]  = 1'b1;
               src_in[cnt_ff]  = item_ff.src_addr;
               pgn_in[cnt_ff]  = item_ff.frame_data[63:40];
               tot_in[cnt_ff]  = ctl_total[10:0];
               left_in[cnt_ff] = item_ff.frame_data[31:24];
               exp_in[cnt_ff]  = 8'd1;
               last_in[cnt_ff] = tick_ff;
               res_in.status   = btr_pkg::ST_OPENED;
               res_in.slot     = 2'(cnt_ff);
               state_in        = S_RESP;
            end else if (last_k) begin
               res_in.status = btr_pkg::ST_NO_SLOT;
               state_in      = S_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DROP: begin
            if (act_ff[cnt_ff] && elapsed >= timeout_ff) begin
               act_in[cnt_ff] = 1'b0;
            end
            if (last_k) begin
               cnt_in   = '0;
               state_in = S_MATCH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MATCH: begin
            if (act_ff[cnt_ff] && src_ff[cnt_ff] == item_ff.src_addr) begin
               slot_in  = cnt_ff;
               state_in = S_PROC;
            end else if (last_k) begin
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_PROC: begin
            res_in.slot = 2'(slot_ff);
            state_in    = S_RESP;
            if (pn != exp_ff[slot_ff]) begin
               res_in.status = btr_pkg::ST_OUT_SEQ;
            end else if (pn == 8'd0 || 32'(pn) > 32'(PACKETS_PER_MESSAGE) ||
                         end2 > {1'b0, maxlen_ff}) begin
               act_in[slot_ff] = 1'b0;
               res_in.status   = btr_pkg::ST_DROPPED;
            end else begin
               wr_en            = 1'b1;
               exp_in[slot_ff]  = exp_ff[slot_ff] + 8'd1;
               left_in[slot_ff] = left_ff[slot_ff] - 8'd1;
               last_in[slot_ff] = tick_ff;
               if (left_ff[slot_ff] == 8'd1) begin
                  act_in[slot_ff]   = 1'b0;
                  res_in.status     = btr_pkg::ST_COMPLETE;
                  res_in.pgn        = pgn_ff[slot_ff];
                  res_in.msg_source = src_ff[slot_ff];
                  res_in.msg_len    = tot_ff[slot_ff];
               end else begin
                  res_in.status = btr_pkg::ST_STORED;
               end
            end
         end
         S_READ: begin
            res_in.word_data = rd_data;
            state_in         = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         act_ff       <= '0;
         timeout_ff   <= btr_pkg::TIMEOUT_RESET;
         maxlen_ff    <= btr_pkg::MAX_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         act_ff       <= act_in;
         if (cfg_wr && pready) begin
            if (paddr[2] == btr_pkg::REG_TIMEOUT) begin
               timeout_ff <= pwdata;
            end else begin
               maxlen_ff <= pwdata[10:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      src_ff  <= src_in;
      pgn_ff  <= pgn_in;
      tot_ff  <= tot_in;
      left_ff <= left_in;
      exp_ff  <= exp_in;
      last_ff <= last_in;
   end

   a_write_in_proc: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_PROC && act_ff[slot_ff]))
      else $error("payload write outside an active session");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == S_RESP))
      else $error("result loaded outside the response state");

   a_meta_only_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != btr_pkg::ST_COMPLETE) |->
      (rsp_ff.pgn == 24'd0 && rsp_ff.msg_len == 11'd0 && rsp_ff.msg_source == 8'd0))
      else $error("message fields set on a non-completion result");

   a_read_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ($past(state_ff) == S_IDLE && $past(rd_en)))
      else $error("read state entered without a memory read");

endmodule
`default_nettype wire

>>> verif/tb_bam_transport_reassembler.sv
// Testbench for the broadcast transport reassembler: directed and random checks against a predictor.
`timescale 1ns / 1ps
module tb_bam_transport_reassembler;

   localparam int SLOTS   = 4;
   localparam int PACKETS = 255;
   localparam int WORDS   = SLOTS * PACKETS;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   btr_pkg::req_type  req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   btr_pkg::rsp_type  rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   bam_transport_reassembler #(.SESSION_SLOTS(SLOTS), .PACKETS_PER_MESSAGE(PACKETS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predicted session table and payload memory.
   logic [31:0] tick_now;
   logic [31:0] timeout_cfg;
   int unsigned max_len_cfg;
   logic        sess_open [SLOTS];
   logic [7:0]  sess_src [SLOTS];
   logic [23:0] sess_pgn [SLOTS];
   int unsigned sess_total [SLOTS];
   logic [7:0]  sess_left [SLOTS];
   logic [7:0]  sess_next [SLOTS];
   logic [31:0] sess_seen [SLOTS];
   logic [55:0] word_mem [WORDS];
   logic [6:0]  word_written [WORDS];
   int          full_words [$];

   btr_pkg::rsp_type expected_rsp [$];
   int          failures;
   int          tx_idle_pct;
   int          rx_idle_pct;
   int          hold_cycles;
   bit          hold_start;
   logic [7:0]  src_pool [6] = '{8'h01, 8'h7E, 8'h80, 8'hFE, 8'h33, 8'hC5};

   function automatic btr_pkg::rsp_type predict_result(btr_pkg::req_type it);
      btr_pkg::rsp_type r;
      logic [7:0]  b [8];
      logic [31:0] elapsed;
      int unsigned total;
      int unsigned off;
      int unsigned chunk;
      int          idx;
      bit          found;
      r = '0;
      found = 0;
      for (int i = 0; i < 8; i++) b[i] = it.frame_data[8*i +: 8];
      case (it.action)
         btr_pkg::ACT_TICK: begin
            tick_now = tick_now + 32'd1;
            r.status = btr_pkg::ST_IGNORED;
         end
         btr_pkg::ACT_CTRL: begin
            r.status = btr_pkg::ST_IGNORED;
            total = {b[2], b[1]};
            if (b[0] == btr_pkg::CTRL_BAM && it.dst_addr == btr_pkg::BROADCAST && total != 0
                && total <= max_len_cfg) begin
               for (int k = 0; k < SLOTS; k++)
                  if (sess_open[k] && sess_src[k] == it.src_addr) sess_open[k] = 0;
               r.status = btr_pkg::ST_NO_SLOT;
               for (int k = 0; k < SLOTS; k++) begin
                  if (!found && !sess_open[k]) begin
                     found = 1;
                     sess_open[k] = 1;
                     sess_pgn[k] = {b[7], b[6], b[5]};
                     sess_src[k] = it.src_addr;
                     sess_total[k] = total;
                     sess_left[k] = b[3];
                     sess_next[k] = 8'd1;
                     sess_seen[k] = tick_now;
                     r.status = btr_pkg::ST_OPENED;
                     r.slot = 2'(k);
                  end
               end
            end
         end
         btr_pkg::ACT_DATA: begin
            r.status = btr_pkg::ST_IGNORED;
            for (int k = 0; k < SLOTS; k++) begin
               elapsed = tick_now - sess_seen[k];
               if (sess_open[k] && elapsed >= timeout_cfg) sess_open[k] = 0;
            end
            for (int k = 0; k < SLOTS; k++) begin
               if (!found && sess_open[k] && sess_src[k] == it.src_addr) begin
                  found = 1;
                  r.slot = 2'(k);
                  if (b[0] != sess_next[k]) begin
                     r.status = btr_pkg::ST_OUT_SEQ;
                  end else if (b[0] == 0) begin
                     sess_open[k] = 0;
                     r.status = btr_pkg::ST_DROPPED;
                  end else begin
                     off = (b[0] - 1) * btr_pkg::WORD_BYTES;
                     chunk = it.frame_len > 1 ? it.frame_len - 1 : 0;
                     if (chunk > btr_pkg::WORD_BYTES) chunk = btr_pkg::WORD_BYTES;
                     if (off + chunk > sess_total[k])
                        chunk = sess_total[k] > off ? sess_total[k] - off : 0;
                     if (off + chunk > max_len_cfg) begin
                        sess_open[k] = 0;
                        r.status = btr_pkg::ST_DROPPED;
                     end else begin
                        idx = k * PACKETS + b[0] - 1;
                        for (int i = 0; i < chunk; i++) begin
                           word_mem[idx][8*i +: 8] = b[i+1];
                           word_written[idx][i] = 1'b1;
                        end
                        if (word_written[idx] == 7'h7F) full_words.push_back(idx);
                        sess_next[k] = sess_next[k] + 8'd1;
                        sess_left[k] = sess_left[k] - 8'd1;
                        sess_seen[k] = tick_now;
                        r.status = btr_pkg::ST_STORED;
                        if (sess_left[k] == 0) begin
                           sess_open[k] = 0;
                           r.status = btr_pkg::ST_COMPLETE;
                           r.pgn = sess_pgn[k];
                           r.msg_source = sess_src[k];
                           r.msg_len = 11'(sess_total[k]);
                        end
                     end
                  end
               end
            end
         end
         default: begin
            r.status = btr_pkg::ST_READ;
            r.slot = it.read_slot;
            if (it.read_index < PACKETS)
               r.word_data = word_mem[it.read_slot * PACKETS + it.read_index];
         end
      endcase
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: checks each transfer, then decides readiness for the next edge.
   always @(posedge clock) begin
      btr_pkg::rsp_type want;
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            $error("result with nothing expected: %h", rsp_payload);
            failures++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_payload.status);
               failures++;
            end
            if (rsp_payload.slot !== want.slot) begin
               $error("slot expected %0d actual %0d", want.slot, rsp_payload.slot);
               failures++;
            end
            if (rsp_payload.pgn !== want.pgn) begin
               $error("pgn expected %h actual %h", want.pgn, rsp_payload.pgn);
               failures++;
            end
            if (rsp_payload.msg_source !== want.msg_source) begin
               $error("msg_source expected %h actual %h", want.msg_source,
                      rsp_payload.msg_source);
               failures++;
            end
            if (rsp_payload.msg_len !== want.msg_len) begin
               $error("msg_len expected %0d actual %0d", want.msg_len, rsp_payload.msg_len);
               failures++;
            end
            if (rsp_payload.word_data !== want.word_data) begin
               $error("word_data expected %h actual %h", want.word_data,
                      rsp_payload.word_data);
               failures++;
            end
         end
      end
      if (hold_start) begin
         hold_start = 0;
         hold_cycles = 400;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_frame(btr_pkg::req_type it);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_rsp.push_back(predict_result(it));
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (addr == 3'(4 * btr_pkg::REG_TIMEOUT)) timeout_cfg = value;
      else max_len_cfg = value[10:0];
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_limits(logic [31:0] timeout, logic [10:0] max_len);
      drain();
      csr_write(3'(4 * btr_pkg::REG_TIMEOUT), timeout);
      csr_write(3'(4 * btr_pkg::REG_MAX_LEN), {21'd0, max_len});
   endtask

   function automatic btr_pkg::req_type noise_frame();
      btr_pkg::req_type it;
      it = btr_pkg::req_type'({$urandom, $urandom, $urandom});
      return it;
   endfunction

   function automatic btr_pkg::req_type ctrl_frame(logic [7:0] src, logic [15:0] total,
                                                   logic [7:0] npk, logic [23:0] pgn);
      btr_pkg::req_type it;
      it = noise_frame();
      it.action = btr_pkg::ACT_CTRL;
      it.src_addr = src;
      it.dst_addr = btr_pkg::BROADCAST;
      it.frame_data = {pgn, it.frame_data[39:32], npk, total, btr_pkg::CTRL_BAM};
      return it;
   endfunction

   function automatic btr_pkg::req_type data_frame(logic [7:0] src, logic [7:0] pn,
                                                   logic [3:0] flen);
      btr_pkg::req_type it;
      it = noise_frame();
      it.action = btr_pkg::ACT_DATA;
      it.src_addr = src;
      it.frame_len = flen;
      it.frame_data[7:0] = pn;
      return it;
   endfunction

   function automatic btr_pkg::req_type read_frame(logic [1:0] slot, logic [7:0] index);
      btr_pkg::req_type it;
      it = noise_frame();
      it.action = btr_pkg::ACT_READ;
      it.read_slot = slot;
      it.read_index = index;
      return it;
   endfunction

   function automatic btr_pkg::req_type tick_frame();
      btr_pkg::req_type it;
      it = noise_frame();
      it.action = btr_pkg::ACT_TICK;
      return it;
   endfunction

   // A read only targets words whose seven bytes have all been stored, or the
   // index past the end, which reads as zero.
   function automatic btr_pkg::req_type safe_read();
      int idx;
      if (full_words.size() == 0 || $urandom_range(9) == 0)
         return read_frame(2'($urandom), 8'hFF);
      idx = full_words[$urandom_range(full_words.size() - 1)];
      return read_frame(2'(idx / PACKETS), 8'(idx % PACKETS));
   endfunction

   task automatic test_ignored_frames();
      btr_pkg::req_type it;
      send_frame(tick_frame());
      it = ctrl_frame(8'h10, 16'd10, 8'd2, 24'h123456);
      it.frame_data[7:0] = 8'd33;
      send_frame(it);
      it = ctrl_frame(8'h10, 16'd10, 8'd2, 24'h123456);
      it.dst_addr = 8'hFE;
      send_frame(it);
      send_frame(ctrl_frame(8'h10, 16'd0, 8'd2, 24'h0));
      send_frame(ctrl_frame(8'h10, 16'hFFFF, 8'd2, 24'h0));
      send_frame(ctrl_frame(8'h10, 16'd1786, 8'd2, 24'h0));
      // A total whose low eleven bits look small is still far too long.
      send_frame(ctrl_frame(8'h10, 16'h0805, 8'd2, 24'h0));
      send_frame(data_frame(8'h55, 8'd1, 4'd8));
      send_frame(read_frame(2'd3, 8'hFF));
   endtask

   task automatic test_short_message();
      send_frame(ctrl_frame(8'hA5, 16'd10, 8'd2, 24'hFFFFFF));
      send_frame(data_frame(8'hA5, 8'd2, 4'd8));
      send_frame(data_frame(8'hA5, 8'd1, 4'd8));
      send_frame(data_frame(8'hA5, 8'd1, 4'd8));
      send_frame(data_frame(8'hA5, 8'd2, 4'd15));
      send_frame(safe_read());
      // Zero announced packets counts as 256; frame lengths of zero and one give empty chunks.
      send_frame(ctrl_frame(8'h5A, 16'd20, 8'd0, 24'h0));
      send_frame(data_frame(8'h5A, 8'd1, 4'd0));
      send_frame(data_frame(8'h5A, 8'd2, 4'd1));
      send_frame(data_frame(8'h5A, 8'd3, 4'd3));
      send_frame(ctrl_frame(8'h5A, 16'd30, 8'd1, 24'h00A0B0));
      send_frame(data_frame(8'h5A, 8'd1, 4'd8));
   endtask

   task automatic test_no_free_slot();
      for (int i = 0; i < 5; i++)
         send_frame(ctrl_frame(src_pool[i], 16'd14, 8'd2, 24'($urandom)));
      send_frame(ctrl_frame(src_pool[0], 16'd7, 8'd1, 24'h0));
      send_frame(data_frame(src_pool[0], 8'd1, 4'd8));
   endtask

   task automatic test_timeout_and_limits();
      set_limits(32'd3, 11'd1785);
      send_frame(ctrl_frame(8'h21, 16'd40, 8'd6, 24'h111111));
      send_frame(data_frame(8'h21, 8'd1, 4'd8));
      repeat (3) send_frame(tick_frame());
      send_frame(data_frame(8'h21, 8'd2, 4'd8));
      set_limits(32'd0, 11'd1);
      send_frame(ctrl_frame(8'h22, 16'd2, 8'd1, 24'h0));
      send_frame(ctrl_frame(8'h22, 16'd1, 8'd1, 24'h0));
      send_frame(data_frame(8'h22, 8'd1, 4'd8));
      // A lowered limit drops a session whose next chunk would pass it.
      set_limits(32'hFFFFFFFF, 11'd1785);
      send_frame(ctrl_frame(8'h23, 16'd100, 8'd15, 24'h222222));
      set_limits(32'hFFFFFFFF, 11'd10);
      send_frame(data_frame(8'h23, 8'd1, 4'd8));
      send_frame(data_frame(8'h23, 8'd2, 4'd8));
      set_limits(32'd750, 11'd1785);
   endtask

   task automatic test_longest_message();
      send_frame(ctrl_frame(8'hEE, 16'd1785, 8'd255, 24'h0F0F0F));
      for (int p = 1; p <= PACKETS; p++) send_frame(data_frame(8'hEE, 8'(p), 4'd8));
      for (int i = 0; i < 8; i++) send_frame(safe_read());
   endtask

   task automatic test_output_stall();
      drain();
      hold_start = 1;
      for (int i = 0; i < 20; i++) send_frame(safe_read());
   endtask

   task automatic test_random_traffic(int count);
      int               pick;
      int               slot_of;
      logic [7:0]       src;
      logic [7:0]       pn;
      int unsigned      total;
      btr_pkg::req_type it;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         src = src_pool[$urandom_range(5)];
         if (pick < 10) begin
            it = tick_frame();
         end else if (pick < 18) begin
            it = noise_frame();
            if (it.action == btr_pkg::ACT_READ) it = safe_read();
         end else if (pick < 30) begin
            it = safe_read();
         end else if (pick < 42) begin
            pick = $urandom_range(99);
            if (pick < 70) total = $urandom_range(40, 1);
            else if (pick < 95) total = $urandom_range(1785, 41);
            else total = $urandom_range(2047);
            it = ctrl_frame(src, 16'(total),
                            $urandom_range(4) == 0 ? 8'($urandom) : 8'((total + 6) / 7),
                            24'($urandom));
         end else begin
            slot_of = -1;
            for (int k = 0; k < SLOTS; k++)
               if (slot_of < 0 && sess_open[k] && sess_src[k] == src) slot_of = k;
            pn = slot_of >= 0 ? sess_next[slot_of] : 8'($urandom_range(3, 1));
            if ($urandom_range(19) == 0) pn = 8'($urandom);
            it = data_frame(src, pn, $urandom_range(4) == 0 ? 4'($urandom) : 4'd8);
         end
         send_frame(it);
      end
   endtask

   initial begin
      failures = 0;
      hold_cycles = 0;
      hold_start = 0;
      tx_idle_pct = 28;
      rx_idle_pct = 52;
      tick_now = '0;
      timeout_cfg = btr_pkg::TIMEOUT_RESET;
      max_len_cfg = btr_pkg::MAX_LEN_RESET;
      for (int k = 0; k < SLOTS; k++) begin
         sess_open[k] = 0;
         sess_src[k] = '0;
         sess_pgn[k] = '0;
         sess_total[k] = 0;
         sess_left[k] = '0;
         sess_next[k] = '0;
         sess_seen[k] = '0;
      end
      for (int w = 0; w < WORDS; w++) begin
         word_mem[w] = '0;
         word_written[w] = '0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_frames();
      test_short_message();
      test_no_free_slot();
      test_timeout_and_limits();
      test_longest_message();
      test_output_stall();

      set_limits(32'd40, 11'd1785);
      test_random_traffic(470);
      set_limits(32'hFFFFFFFF, 11'd1785);
      tx_idle_pct = 52;
      rx_idle_pct = 28;
      test_random_traffic(470);
      set_limits(32'd25, 11'd300);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_traffic(470);

      drain();
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/btr_pkg.sv
design/btr_payload_ram.sv
design/bam_transport_reassembler.sv
verif/tb_bam_transport_reassembler.sv
